// ===== rtl/fpmv_pkg.sv =====
// fpmv_pkg: shared types, constants and binary32 arithmetic functions
// for the fp32 matrix-vector multiply core; depends on nothing
package fpmv_pkg;

  localparam int unsigned COLS_MAX_DEF = 1024;
  localparam int unsigned ROWS_MAX_DEF = 65536;
  localparam int unsigned WQ_DEPTH = 4;
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned WQ_CNT_W = $clog2(WQ_DEPTH + 1);
  localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);
  localparam int unsigned PADDR_W = 3;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  typedef enum logic {
    REG_COLS = 1'b0,
    REG_ROWS = 1'b1
  } reg_idx_e;

  typedef enum logic {
    MODE_VECTOR = 1'b0,
    MODE_MATRIX = 1'b1
  } mode_e;

  typedef struct packed {
    logic        mode;
    logic [9:0]  vector_index;
    logic [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] row_sum;
    logic [15:0] row_number;
    logic        last_row;
  } out_item_t;

  typedef struct packed {
    logic [31:0] element;
    logic [31:0] vec;
    logic        end_row;
    logic [15:0] row_number;
    logic        last_row;
  } work_t;

  function automatic logic is_nan(logic [31:0] x);
    return x[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic is_inf(logic [31:0] x);
    return x[30:0] == 31'h7F80_0000;
  endfunction

  function automatic logic is_zero(logic [31:0] x);
    return x[30:0] == 31'h0;
  endfunction

  function automatic int unpack_exp(logic [31:0] x);
    return (x[30:23] == 8'h0) ? 1 : int'({24'h0, x[30:23]});
  endfunction

  function automatic logic [63:0] unpack_man(logic [31:0] x);
    return (x[30:23] == 8'h0) ? {41'h0, x[22:0]} : {40'h0, 1'b1, x[22:0]};
  endfunction

  // value = m * 2^e, nearest even
  function automatic logic [31:0] round_pack(logic s, int e, logic [63:0] m);
    int          p;
    int          be;
    int          sh;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    p = 0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) p = i;
    end
    be = e + 150 + p - 23;
    if (be < 1) be = 1;
    sh = be - 150 - e;
    rem = '0;
    half = '0;
    if (sh <= 0) begin
      mant = m << (-sh);
    end else if (sh >= 63) begin
      mant = '0;
    end else begin
      rem = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      mant = m >> sh;
      if (rem > half || (rem == half && mant[0])) mant = mant + 64'd1;
    end
    if (mant == (64'd1 << 24)) begin
      mant = mant >> 1;
      be = be + 1;
    end
    if (be >= 255) return {s, 8'hFF, 23'h0};
    if (mant >= (64'd1 << 23)) return {s, be[7:0], mant[22:0]};
    return {s, 8'h00, mant[22:0]};
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic        sa;
    logic        sb;
    logic        sr;
    logic        ts;
    int          ea;
    int          eb;
    int          te;
    int          d;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] tm;
    logic [63:0] lost;
    logic [63:0] r;
    sa = a[31];
    sb = b[31];
    if (is_nan(a) || is_nan(b)) return QNAN;
    if (is_inf(a) && is_inf(b)) return (sa == sb) ? a : QNAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {sa & sb, 31'h0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    ea = unpack_exp(a);
    ma = unpack_man(a);
    eb = unpack_exp(b);
    mb = unpack_man(b);
    if (eb > ea) begin
      ts = sa; te = ea; tm = ma;
      sa = sb; ea = eb; ma = mb;
      sb = ts; eb = te; mb = tm;
    end
    d = ea - eb;
    ma = ma << 30;
    mb = mb << 30;
    if (d >= 62) begin
      mb = 64'd1;
    end else if (d > 0) begin
      lost = mb & ((64'd1 << d) - 64'd1);
      mb = (mb >> d) | {63'h0, lost != 64'h0};
    end
    if (sa == sb) begin
      r = ma + mb;
      sr = sa;
    end else if (ma >= mb) begin
      r = ma - mb;
      sr = sa;
    end else begin
      r = mb - ma;
      sr = sb;
    end
    if (r == 64'h0) return 32'h0;
    return round_pack(sr, ea - 180, r);
  endfunction

endpackage

// ===== rtl/fp32_matrix_vector_multiply_core.sv =====
// channel   direction  handshake           payload
// input     in         push / full         in_data_i  (mode, vector_index, element_value)
// result    out        pop / empty         out_data_o (row_sum, row_number, last_row)
// config    in         psel/penable/pready paddr, pwdata, prdata
//
// one word per cycle while full stays low; the fp add of the row accumulator is combinational
// an accepted matrix word passes the ram read stage, the work queue and two multiply
// stages before the accumulate feeds the result queue; vector loads produce nothing
// reset clears counters, accumulator and queues; the vector store is not cleared
// full rises when the work queue plus the ram read stage can hold no more words;
// the back end stalls only when the result queue could fill
module fp32_matrix_vector_multiply_core #(
  parameter int unsigned COLS_MAX = fpmv_pkg::COLS_MAX_DEF,
  parameter int unsigned ROWS_MAX = fpmv_pkg::ROWS_MAX_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  fpmv_pkg::in_item_t           in_data_i,
  output logic                         empty,
  input  logic                         pop,
  output fpmv_pkg::out_item_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpmv_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [10:0]                   cols_q;
  logic [16:0]                   rows_q;
  logic                          cfg_we;
  fpmv_pkg::reg_idx_e            reg_idx;

  logic                          wq_push;
  fpmv_pkg::work_t               wq_wdata;
  fpmv_pkg::work_t               wq_rdata;
  logic                          wq_pop;
  logic                          wq_empty;
  logic [fpmv_pkg::WQ_CNT_W-1:0] wq_cnt;

  logic                          rq_push;
  fpmv_pkg::out_item_t           rq_wdata;
  logic [fpmv_pkg::RQ_CNT_W-1:0] rq_cnt;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_idx = fpmv_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 11'd1024;
      rows_q <= 17'd1;
    end else if (cfg_we) begin
      case (reg_idx)
        fpmv_pkg::REG_COLS: cols_q <= pwdata[10:0];
        fpmv_pkg::REG_ROWS: rows_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      fpmv_pkg::REG_COLS: prdata = {21'h0, cols_q};
      fpmv_pkg::REG_ROWS: prdata = {15'h0, rows_q};
      default:            prdata = '0;
    endcase
  end

  fpmv_front #(
    .COLS_MAX (COLS_MAX),
    .ROWS_MAX (ROWS_MAX)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .full_o    (full),
    .cols_i    (cols_q),
    .rows_i    (rows_q),
    .wq_cnt_i  (wq_cnt),
    .wq_push_o (wq_push),
    .wq_data_o (wq_wdata)
  );

  fpmv_fifo #(
    .WIDTH ($bits(fpmv_pkg::work_t)),
    .DEPTH (fpmv_pkg::WQ_DEPTH)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (wq_push),
    .wdata_i (wq_wdata),
    .pop_i   (wq_pop),
    .rdata_o (wq_rdata),
    .empty_o (wq_empty),
    .count_o (wq_cnt)
  );

  fpmv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wq_empty_i (wq_empty),
    .wq_data_i  (wq_rdata),
    .wq_pop_o   (wq_pop),
    .rq_cnt_i   (rq_cnt),
    .rq_push_o  (rq_push),
    .rq_data_o  (rq_wdata)
  );

  fpmv_fifo #(
    .WIDTH ($bits(fpmv_pkg::out_item_t)),
    .DEPTH (fpmv_pkg::RQ_DEPTH)
  ) u_result_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rq_push),
    .wdata_i (rq_wdata),
    .pop_i   (pop && !empty),
    .rdata_o (out_data_o),
    .empty_o (empty),
    .count_o (rq_cnt)
  );

  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty == (rq_cnt == '0))
    else $error("result queue empty flag mismatch");

  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> 32'(wq_cnt) < fpmv_pkg::WQ_DEPTH)
    else $error("input taken with no work queue room");

  a_cfg_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we && reg_idx == fpmv_pkg::REG_ROWS |=> rows_q == $past(pwdata[16:0]))
    else $error("row count register write lost");

endmodule

// ===== rtl/fpmv_ram.sv =====
// fpmv_ram: generic single-write, single-read ram with registered read
// depends on nothing
module fpmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fpmv_fifo.sv =====
// fpmv_fifo: small register queue with fill count; its pointers wrap at any depth
// depends on nothing
module fpmv_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic [WIDTH-1:0]             wdata_i,
  input  logic                         pop_i,
  output logic [WIDTH-1:0]             rdata_o,
  output logic                         empty_o,
  output logic [$clog2(DEPTH+1)-1:0]   count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + PW'(1);
    if (pop_i)  rd_d = (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + PW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CW'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - CW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  assign rdata_o = mem_q[rd_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// ===== rtl/fpmv_front.sv =====
// fpmv_front: accepts items, loads the vector store, tags matrix elements with row
// number and row-end/last-row flags and fetches their vector entry by column; uses fpmv_pkg, fpmv_ram
module fpmv_front #(
  parameter int unsigned COLS_MAX = fpmv_pkg::COLS_MAX_DEF,
  parameter int unsigned ROWS_MAX = fpmv_pkg::ROWS_MAX_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  fpmv_pkg::in_item_t            in_data_i,
  output logic                          full_o,
  input  logic [10:0]                   cols_i,
  input  logic [16:0]                   rows_i,
  input  logic [fpmv_pkg::WQ_CNT_W-1:0] wq_cnt_i,
  output logic                          wq_push_o,
  output fpmv_pkg::work_t               wq_data_o
);

  localparam int unsigned AW  = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int unsigned CCW = $clog2(COLS_MAX + 1);
  localparam int unsigned RCW = $clog2(ROWS_MAX + 1);

  logic           accept;
  logic           is_mat;
  logic           vec_we;
  logic [CCW-1:0] cols_eff;
  logic [RCW-1:0] rows_eff;
  logic [CCW-1:0] cc_q, cc_d;
  logic [RCW-1:0] rc_q, rc_d;
  logic           row_end;
  logic           row_last;
  logic [31:0]    vec_rdata;

  logic           s1_v_q;
  logic [31:0]    s1_elem_q;
  logic           s1_end_q;
  logic [15:0]    s1_rn_q;
  logic           s1_last_q;

  assign full_o = (32'(wq_cnt_i) + 32'(s1_v_q)) >= fpmv_pkg::WQ_DEPTH;
  assign accept = push_i && !full_o;
  assign is_mat = (in_data_i.mode == fpmv_pkg::MODE_MATRIX);
  assign vec_we = accept && !is_mat && (32'(in_data_i.vector_index) < COLS_MAX);

  always_comb begin
    if (cols_i == '0) begin
      cols_eff = CCW'(1);
    end else if (32'(cols_i) > COLS_MAX) begin
      cols_eff = CCW'(COLS_MAX);
    end else begin
      cols_eff = CCW'(cols_i);
    end
    if (rows_i == '0) begin
      rows_eff = RCW'(1);
    end else if (32'(rows_i) > ROWS_MAX) begin
      rows_eff = RCW'(ROWS_MAX);
    end else begin
      rows_eff = RCW'(rows_i);
    end
  end

  assign row_end  = (32'(cc_q) + 32'd1) >= 32'(cols_eff);
  assign row_last = (32'(rc_q) + 32'd1) >= 32'(rows_eff);

  always_comb begin
    cc_d = cc_q;
    rc_d = rc_q;
    if (accept && is_mat) begin
      if (row_end) begin
        cc_d = '0;
        rc_d = row_last ? '0 : rc_q + RCW'(1);
      end else begin
        cc_d = cc_q + CCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cc_q   <= '0;
      rc_q   <= '0;
      s1_v_q <= 1'b0;
    end else begin
      cc_q   <= cc_d;
      rc_q   <= rc_d;
      s1_v_q <= accept && is_mat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_mat) begin
      s1_elem_q <= in_data_i.element_value;
      s1_end_q  <= row_end;
      s1_rn_q   <= 16'(rc_q);
      s1_last_q <= row_last;
    end
  end

  fpmv_ram #(
    .WIDTH (32),
    .DEPTH (COLS_MAX)
  ) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (AW'(in_data_i.vector_index)),
    .wdata_i (in_data_i.element_value),
    .re_i    (accept && is_mat),
    .raddr_i (cc_q[AW-1:0]),
    .rdata_o (vec_rdata)
  );

  assign wq_push_o             = s1_v_q;
  assign wq_data_o.element     = s1_elem_q;
  assign wq_data_o.vec         = vec_rdata;
  assign wq_data_o.end_row     = s1_end_q;
  assign wq_data_o.row_number  = s1_rn_q;
  assign wq_data_o.last_row    = s1_last_q;

  a_cc_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cc_q) < COLS_MAX)
    else $error("column counter out of range");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_mat && row_end |=> cc_q == '0)
    else $error("column counter not cleared at row end");

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wq_push_o |-> 32'(wq_cnt_i) < fpmv_pkg::WQ_DEPTH)
    else $error("work queue overflow");

endmodule

// ===== rtl/fpmv_back.sv =====
// fpmv_back: two-stage binary32 multiply and an accumulate loop with a combinational add,
// emits row sums; uses fpmv_pkg
module fpmv_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wq_empty_i,
  input  fpmv_pkg::work_t               wq_data_i,
  output logic                          wq_pop_o,
  input  logic [fpmv_pkg::RQ_CNT_W-1:0] rq_cnt_i,
  output logic                          rq_push_o,
  output fpmv_pkg::out_item_t           rq_data_o
);

  logic               m1_v_q;
  logic               m1_spec_q;
  logic [31:0]        m1_sval_q;
  logic               m1_sign_q;
  logic signed [11:0] m1_exp_q;
  logic [47:0]        m1_prod_q;
  logic               m1_end_q;
  logic [15:0]        m1_rn_q;
  logic               m1_last_q;

  logic               m2_v_q;
  logic [31:0]        m2_prod_q;
  logic               m2_end_q;
  logic [15:0]        m2_rn_q;
  logic               m2_last_q;

  logic [31:0]        acc_q, acc_d;
  logic [31:0]        sum;

  logic [31:0]        a;
  logic [31:0]        b;
  logic               sgn;
  logic               spec;
  logic [31:0]        sval;
  logic [63:0]        ma;
  logic [63:0]        mb;

  assign wq_pop_o = !wq_empty_i &&
    ((32'(rq_cnt_i) + 32'(m1_v_q) + 32'(m2_v_q)) < fpmv_pkg::RQ_DEPTH);

  always_comb begin
    a    = wq_data_i.element;
    b    = wq_data_i.vec;
    sgn  = a[31] ^ b[31];
    spec = 1'b1;
    sval = {sgn, 31'h0};
    ma   = fpmv_pkg::unpack_man(a);
    mb   = fpmv_pkg::unpack_man(b);
    if (fpmv_pkg::is_nan(a) || fpmv_pkg::is_nan(b)) begin
      sval = fpmv_pkg::QNAN;
    end else if (fpmv_pkg::is_inf(a) || fpmv_pkg::is_inf(b)) begin
      sval = (fpmv_pkg::is_zero(a) || fpmv_pkg::is_zero(b)) ? fpmv_pkg::QNAN
                                                             : {sgn, 8'hFF, 23'h0};
    end else if (!(fpmv_pkg::is_zero(a) || fpmv_pkg::is_zero(b))) begin
      spec = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      m1_v_q <= wq_pop_o;
      m2_v_q <= m1_v_q;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wq_pop_o) begin
      m1_spec_q <= spec;
      m1_sval_q <= sval;
      m1_sign_q <= sgn;
      m1_exp_q  <= 12'(fpmv_pkg::unpack_exp(a) + fpmv_pkg::unpack_exp(b) - 300);
      m1_prod_q <= ma[23:0] * mb[23:0];
      m1_end_q  <= wq_data_i.end_row;
      m1_rn_q   <= wq_data_i.row_number;
      m1_last_q <= wq_data_i.last_row;
    end
    if (m1_v_q) begin
      m2_prod_q <= m1_spec_q ? m1_sval_q
                 : fpmv_pkg::round_pack(m1_sign_q, int'(m1_exp_q), {16'h0, m1_prod_q});
      m2_end_q  <= m1_end_q;
      m2_rn_q   <= m1_rn_q;
      m2_last_q <= m1_last_q;
    end
  end

  // accumulate loop
  always_comb begin
    sum   = fpmv_pkg::fp_add(acc_q, m2_prod_q);
    acc_d = acc_q;
    if (m2_v_q) acc_d = m2_end_q ? 32'h0 : sum;
  end

  assign rq_push_o            = m2_v_q && m2_end_q;
  assign rq_data_o.row_sum    = sum;
  assign rq_data_o.row_number = m2_rn_q;
  assign rq_data_o.last_row   = m2_last_q;

  a_rq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_push_o |-> 32'(rq_cnt_i) < fpmv_pkg::RQ_DEPTH)
    else $error("result queue overflow");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_push_o |=> acc_q == 32'h0)
    else $error("accumulator not cleared after row");

  a_pipe_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wq_pop_o |=> m1_v_q ##1 m2_v_q)
    else $error("multiply pipeline lost an element");

endmodule
